FILE: src/audstair_pkg.sv
// Shared types, codes, constants and lookup tables for the staircase sequencer.
`timescale 1ns / 1ps
`default_nettype none

package audstair_pkg;

   // Fixed field widths
   localparam int OP_W     = 2;
   localparam int DRAW_W   = 6;
   localparam int RESP_W   = 2;
   localparam int STATUS_W = 2;
   localparam int OPTION_W = 2;
   localparam int FREQ_W   = 3;
   localparam int LEVEL_W  = 4;
   localparam int TRIAL_W  = 6;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 6;

   // Staircase constants
   localparam int MAX_LEVEL  = 9;
   localparam int DRAW_RANGE = 36;
   localparam int DRAW_SPAN  = 2 ** DRAW_W;
   localparam int NUM_OPTIONS = 3;

   // Stream widths (payload padded to whole bytes)
   localparam int REQ_DATA_W = 8;
   localparam int RSP_DATA_W = 24;
   localparam int RSP_USED_W = 19;

   // Register reset values
   localparam logic [TRIAL_W-1:0] MAX_TRIALS_RST = TRIAL_W'(20);
   localparam logic [LEVEL_W-1:0] STOP_LEVEL_RST = LEVEL_W'(0);
   localparam logic [FREQ_W-1:0]  FREQ_COUNT_RST = FREQ_W'(6);
   localparam logic               TWO_EARS_RST   = 1'b1;

   // Operation codes carried in req_tuser
   typedef enum logic [OP_W-1:0] {
      OP_START  = 2'd0,
      OP_ASK    = 2'd1,
      OP_ANSWER = 2'd2
   } op_type;

   // Result status codes carried in rsp_tuser
   typedef enum logic [STATUS_W-1:0] {
      STATUS_ACCEPTED = 2'd0,
      STATUS_REJECTED = 2'd1,
      STATUS_IGNORED  = 2'd2
   } status_type;

   // Configuration register indexes
   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MAX_TRIALS = 2'd0,
      CSR_STOP_LEVEL = 2'd1,
      CSR_FREQ_COUNT = 2'd2,
      CSR_TWO_EARS   = 2'd3
   } csr_index_type;

   // Result fields, packed lowest field in the lowest bits
   typedef struct packed {
      logic                test_done;
      logic                freq_done;
      logic [TRIAL_W-1:0]  trial_count;
      logic                ear;
      logic [LEVEL_W-1:0]  level;
      logic [FREQ_W-1:0]   freq_index;
      logic                correct;
      logic [OPTION_W-1:0] play_option;
   } rsp_fields_type;

   typedef logic [DRAW_W-1:0]   draw_table_type   [DRAW_SPAN];
   typedef logic [OPTION_W-1:0] option_table_type [DRAW_SPAN];

   // Raw draw reduced into the draw range
   function automatic draw_table_type build_reduce_table();
      draw_table_type t;
      for (int i = 0; i < DRAW_SPAN; i++) begin
         t[i] = DRAW_W'(i % DRAW_RANGE);
      end
      return t;
   endfunction

   // Raw draw mapped to option A, B or C (1..3)
   function automatic option_table_type build_option_table();
      option_table_type t;
      for (int i = 0; i < DRAW_SPAN; i++) begin
         t[i] = OPTION_W'((i % DRAW_RANGE) % NUM_OPTIONS + 1);
      end
      return t;
   endfunction

   localparam draw_table_type   DRAW_REDUCE_TABLE = build_reduce_table();
   localparam option_table_type DRAW_OPTION_TABLE = build_option_table();

endpackage

`default_nettype wire

FILE: src/audiometry_staircase_sequencer_top.sv
// Top level of the three-choice staircase hearing-test sequencer.
`timescale 1ns / 1ps
`default_nettype none

// One result transaction per request transaction, one request per clock sustained
// while rsp is not back-pressured. A request is captured in an input register,
// evaluated against the test state, and its result lands in the output register,
// which drives rsp. The state update is a combinational loop through the state
// registers (level step, trial counter, frequency/ear advance), which is what
// sets the rate. Back-pressure on rsp holds the input register and then
// req_tready. Op codes: 0 start, 1 ask, 2 answer; op 3 is ignored. CSR writes
// belong in idle time only.
module audiometry_staircase_sequencer_top (
   input  wire logic                                clock,
   input  wire logic                                reset,
   // request stream
   input  wire logic                                req_tvalid,
   output      logic                                req_tready,
   input  wire logic [audstair_pkg::REQ_DATA_W-1:0] req_tdata,  // rand_draw[5:0], response[7:6]
   input  wire logic [audstair_pkg::OP_W-1:0]       req_tuser,  // op[1:0]
   // result stream
   output      logic                                rsp_tvalid,
   input  wire logic                                rsp_tready,
   // play_option[1:0], correct[2], freq_index[5:3], level[9:6], ear[10],
   // trial_count[16:11], freq_done[17], test_done[18], zero[23:19]
   output      logic [audstair_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output      logic [audstair_pkg::STATUS_W-1:0]   rsp_tuser,  // status[1:0]
   // configuration writes
   input  wire logic                                csr_wr_en,
   input  wire logic [audstair_pkg::CSR_IDX_W-1:0]  csr_index,
   input  wire logic [audstair_pkg::CSR_DATA_W-1:0] csr_wdata
);

   // Input register
   logic                              in_valid_ff;
   logic [audstair_pkg::OP_W-1:0]     in_op_ff;
   logic [audstair_pkg::DRAW_W-1:0]   in_draw_ff;
   logic [audstair_pkg::RESP_W-1:0]   in_resp_ff;

   // Output register
   logic                              out_valid_ff;
   audstair_pkg::rsp_fields_type      out_fields_ff, out_fields_in;
   audstair_pkg::status_type          out_status_ff, out_status_in;

   // Configuration registers
   logic [audstair_pkg::TRIAL_W-1:0]  max_trials_ff;
   logic [audstair_pkg::LEVEL_W-1:0]  stop_level_ff;
   logic [audstair_pkg::FREQ_W-1:0]   freq_count_ff;
   logic                              two_ears_ff;

   // Test state
   logic                              active_ff, active_in;
   logic [audstair_pkg::LEVEL_W-1:0]  level_ff, level_in;
   logic [audstair_pkg::TRIAL_W-1:0]  trials_ff, trials_in;
   logic [audstair_pkg::FREQ_W-1:0]   freq_pos_ff, freq_pos_in;
   logic                              right_ear_ff, right_ear_in;
   logic [audstair_pkg::OPTION_W-1:0] asked_ff, asked_in;
   logic [audstair_pkg::DRAW_W-1:0]   last_draw_ff, last_draw_in;

   // Evaluation helpers
   logic                              advance;
   logic [audstair_pkg::DRAW_W-1:0]   draw_reduced;
   logic [audstair_pkg::OPTION_W-1:0] draw_option;
   logic [audstair_pkg::LEVEL_W-1:0]  level_step;
   logic                              is_correct;
   logic                              ear_last_freq;

   // Flow control: the evaluate stage moves when the output register is free
   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;

   // Input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
      if (req_tready && req_tvalid) begin
         in_op_ff   <= req_tuser;
         in_draw_ff <= req_tdata[audstair_pkg::DRAW_W-1:0];
         in_resp_ff <= req_tdata[audstair_pkg::DRAW_W +: audstair_pkg::RESP_W];
      end
   end

   // Configuration writes
   always_ff @(posedge clock) begin
      if (reset) begin
         max_trials_ff <= audstair_pkg::MAX_TRIALS_RST;
         stop_level_ff <= audstair_pkg::STOP_LEVEL_RST;
         freq_count_ff <= audstair_pkg::FREQ_COUNT_RST;
         two_ears_ff   <= audstair_pkg::TWO_EARS_RST;
      end else if (csr_wr_en) begin
         case (csr_index)
            audstair_pkg::CSR_MAX_TRIALS: begin
               max_trials_ff <= csr_wdata[audstair_pkg::TRIAL_W-1:0];
            end
            audstair_pkg::CSR_STOP_LEVEL: begin
               stop_level_ff <= csr_wdata[audstair_pkg::LEVEL_W-1:0];
            end
            audstair_pkg::CSR_FREQ_COUNT: begin
               freq_count_ff <= csr_wdata[audstair_pkg::FREQ_W-1:0];
            end
            audstair_pkg::CSR_TWO_EARS: begin
               two_ears_ff <= csr_wdata[0];
            end
            default: begin
            end
         endcase
      end
   end

   // Draw lookup: reduce into range, pick option
   assign draw_reduced = audstair_pkg::DRAW_REDUCE_TABLE[in_draw_ff];
   assign draw_option  = audstair_pkg::DRAW_OPTION_TABLE[in_draw_ff];

   // Answer evaluation: saturating level step and frequency end checks
   assign is_correct = (in_resp_ff == asked_ff);
   always_comb begin
      level_step = level_ff;
      if (is_correct) begin
         if (level_ff != '0) begin
            level_step = level_ff - audstair_pkg::LEVEL_W'(1);
         end
      end else if (level_ff < audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL)) begin
         level_step = level_ff + audstair_pkg::LEVEL_W'(1);
      end
   end
   assign ear_last_freq = ({1'b0, freq_pos_ff} + 4'd1) >= {1'b0, freq_count_ff};

   // Next state and result
   always_comb begin
      active_in     = active_ff;
      level_in      = level_ff;
      trials_in     = trials_ff;
      freq_pos_in   = freq_pos_ff;
      right_ear_in  = right_ear_ff;
      asked_in      = asked_ff;
      last_draw_in  = last_draw_ff;
      out_status_in = audstair_pkg::STATUS_ACCEPTED;
      out_fields_in = '0;

      case (in_op_ff)
         audstair_pkg::OP_START: begin
            active_in    = 1'b1;
            freq_pos_in  = '0;
            right_ear_in = 1'b0;
            level_in     = audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL);
            trials_in    = '0;
            asked_in     = '0;
         end
         audstair_pkg::OP_ASK: begin
            if (!active_ff) begin
               out_status_in = audstair_pkg::STATUS_IGNORED;
            end else if (draw_reduced == last_draw_ff) begin
               out_status_in = audstair_pkg::STATUS_REJECTED;
            end else begin
               last_draw_in              = draw_reduced;
               asked_in                  = draw_option;
               out_fields_in.play_option = draw_option;
               if (trials_ff != '1) begin
                  trials_in = trials_ff + audstair_pkg::TRIAL_W'(1);
               end
            end
         end
         audstair_pkg::OP_ANSWER: begin
            if (!active_ff) begin
               out_status_in = audstair_pkg::STATUS_IGNORED;
            end else begin
               out_fields_in.correct = is_correct;
               asked_in = '0;
               level_in = level_step;
               if (level_step <= stop_level_ff || level_step == '0 ||
                   trials_ff >= max_trials_ff) begin
                  out_fields_in.freq_done = 1'b1;
                  level_in  = audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL);
                  trials_in = '0;
                  if (ear_last_freq) begin
                     freq_pos_in = '0;
                     if (two_ears_ff && !right_ear_ff) begin
                        right_ear_in = 1'b1;
                     end else begin
                        out_fields_in.test_done = 1'b1;
                        active_in    = 1'b0;
                        right_ear_in = 1'b0;
                     end
                  end else begin
                     freq_pos_in = freq_pos_ff + audstair_pkg::FREQ_W'(1);
                  end
               end
            end
         end
         default: begin
            out_status_in = audstair_pkg::STATUS_IGNORED;
         end
      endcase

      out_fields_in.freq_index  = freq_pos_in;
      out_fields_in.level       = level_in;
      out_fields_in.ear         = right_ear_in;
      out_fields_in.trial_count = trials_in;
   end

   // State and output registers
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff    <= 1'b0;
         level_ff     <= audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL);
         trials_ff    <= '0;
         freq_pos_ff  <= '0;
         right_ear_ff <= 1'b0;
         asked_ff     <= '0;
         last_draw_ff <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (advance) begin
            active_ff    <= active_in;
            level_ff     <= level_in;
            trials_ff    <= trials_in;
            freq_pos_ff  <= freq_pos_in;
            right_ear_ff <= right_ear_in;
            asked_ff     <= asked_in;
            last_draw_ff <= last_draw_in;
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
      if (advance) begin
         out_fields_ff <= out_fields_in;
         out_status_ff <= out_status_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {{(audstair_pkg::RSP_DATA_W - audstair_pkg::RSP_USED_W){1'b0}},
                        out_fields_ff};
   assign rsp_tuser  = out_status_ff;

endmodule

`default_nettype wire

FILE: src/audstair_checker.sv
// Port-level checker for the staircase sequencer, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none

module audstair_checker (
   input wire logic                                clock,
   input wire logic                                reset,
   input wire logic                                rsp_tvalid,
   input wire logic                                rsp_tready,
   input wire logic [audstair_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input wire logic [audstair_pkg::STATUS_W-1:0]   rsp_tuser
);

   audstair_pkg::rsp_fields_type f;
   assign f = audstair_pkg::rsp_fields_type'(rsp_tdata[audstair_pkg::RSP_USED_W-1:0]);

   // Stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("result changed while stalled");

   // Non-accepted transactions carry no ask or answer effects
   a_not_accepted_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser != audstair_pkg::STATUS_ACCEPTED |->
         f.play_option == '0 && !f.correct && !f.freq_done && !f.test_done)
      else $error("rejected or ignored transaction shows effects");

   // Test end is a frequency end that rewinds to first frequency, left ear, top level
   a_test_done_rewinds: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && f.test_done |->
         f.freq_done && f.freq_index == '0 && !f.ear &&
         f.level == audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL) && f.trial_count == '0)
      else $error("test end without full rewind");

   // Level never leaves its range
   a_level_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> f.level <= audstair_pkg::LEVEL_W'(audstair_pkg::MAX_LEVEL))
      else $error("level out of range");

   // A played option comes with a nonzero trial count and no answer flags
   a_play_is_ask: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && f.play_option != '0 |->
         f.trial_count != '0 && !f.correct && !f.freq_done)
      else $error("played option on a non-ask result");

endmodule

bind audiometry_staircase_sequencer_top audstair_checker u_audstair_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);

`default_nettype wire
